/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL files. Every check is clocked on clk_i
// and switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define TTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define TTC_ASSERT_NEVER(lbl, expr, msg) \
  `TTC_ASSERT(lbl, !(expr), msg)

`endif

/* sv/ttc_pkg.sv */
`default_nettype none
package ttc_pkg;

  localparam int StampW = 48;
  localparam int CountW = 13;
  localparam int PairW  = 25;
  localparam int RatioW = 64;
  localparam int LagW   = 32;
  localparam int DenW   = 35;

  typedef enum logic [1:0] {
    FUNC_APPEND_B = 2'd0,
    FUNC_APPEND_A = 2'd1,
    FUNC_COMPUTE  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_ZERO_WIN = 2'd2,
    STATUS_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic {
    CFG_LAG_MIN = 1'b0,
    CFG_LAG_MAX = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE, S_LAST, S_TLAST, S_LEAD, S_LEAD_CHK, S_RDA, S_GETA,
    S_LOW, S_LOW_CHK, S_HIGH, S_HIGH_CHK, S_ACC, S_DIV, S_DIV_WAIT, S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]        func;
    logic [StampW-1:0] stamp;
  } item_t;

  typedef struct packed {
    logic [CountW-1:0]        count_a_early;
    logic [CountW-1:0]        count_b_late;
    logic [PairW-1:0]         pair_count;
    logic signed [RatioW-1:0] span_ratio;
    logic [1:0]               status;
  } result_t;

endpackage
`default_nettype wire

/* sv/ttc_ram.sv */
`default_nettype none
module ttc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

/* sv/ttc_divider.sv */
`default_nettype none
`include "assert_macros.svh"
module ttc_divider #(
  parameter int NUM_W  = 50,
  parameter int FRAC_W = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic signed [NUM_W-1:0]           num_i,
  input  wire logic signed [ttc_pkg::DenW-1:0]   den_i,
  output logic                                   done_o,
  output logic        [ttc_pkg::RatioW-1:0]      quo_o
);

  localparam int DenW = ttc_pkg::DenW;
  localparam int QW   = NUM_W + FRAC_W;
  localparam int CntW = $clog2(QW + 1);
  localparam int WW   = ((QW > ttc_pkg::RatioW) ? QW : ttc_pkg::RatioW) + 1;
  localparam int RW   = ttc_pkg::RatioW;

  logic            run_q, run_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [QW-1:0]   dvd_q, dvd_d;
  logic [QW-1:0]   quo_q, quo_d;
  logic [DenW-1:0] den_q, den_d;
  logic            neg_q, neg_d;

  logic [NUM_W-1:0] num_mag;
  logic [DenW-1:0]  den_mag;
  logic [DenW:0]    rem_sh;
  logic             fits;
  logic [WW-1:0]    q_ext, lim;
  logic [RW-1:0]    q_sat;

  assign num_mag = num_i[NUM_W-1] ? (~num_i + 1'b1) : num_i;
  assign den_mag = den_i[DenW-1] ? (~den_i + 1'b1) : den_i;
  assign rem_sh  = {rem_q[DenW-1:0], dvd_q[QW-1]};
  assign fits    = rem_sh >= {1'b0, den_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    if (start_i && !run_q) begin
      run_d = 1'b1;
      cnt_d = CntW'(QW);
      rem_d = '0;
      dvd_d = QW'(num_mag) << FRAC_W;
      quo_d = '0;
      den_d = den_mag;
      neg_d = num_i[NUM_W-1] ^ den_i[DenW-1];
    end else if (run_q) begin
      // One restoring step per cycle, quotient bits arrive most significant first.
      rem_d = fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
      quo_d = {quo_q[QW-2:0], fits};
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  // The negative bound is one larger in magnitude than the positive one.
  always_comb begin
    q_ext = WW'(quo_q);
    lim   = neg_q ? WW'({1'b1, {(RW-1){1'b0}}}) : WW'({1'b0, {(RW-1){1'b1}}});
    q_sat = (q_ext > lim) ? lim[RW-1:0] : q_ext[RW-1:0];
    quo_o = neg_q ? (~q_sat + 1'b1) : q_sat;
  end

  assign done_o = done_q;

  `TTC_ASSERT(a_done_single, done_q |=> !done_q, "divider done held for two cycles")
  `TTC_ASSERT(a_done_after_run, done_q |-> $past(run_q), "divider done without a run")

endmodule
`default_nettype wire

/* sv/time_tag_window_correlator.sv */
`default_nettype none
`include "assert_macros.svh"
// Time-tag window correlator.
// Items are offered on item_i with start; a transfer happens on a cycle where
// start is high and busy is low. An append (to list A or B) leaves busy low,
// so a photon counter can stream one stamp per cycle. A compute command
// raises busy while the block walks both list memories: it fetches the last
// stamps, probes the leading B run, then per A entry reads the stamp and
// steps the low and high pointers into B, then, unless the window is zero,
// runs the bit-serial ratio divider (NUM_W = 50 at default widths). Each B
// probe has an address and a check state, as the list memories have one
// registered read. The result appears on result_o for exactly one cycle
// with result_valid_o high; it cannot be held off, and busy falls in the
// following cycle. A compute with an empty list answers in the cycle after
// its transfer. Every compute empties both lists. Registers lag_min and
// lag_max are written through cfg_we_i; the user must write them only while
// busy is low, which the block does not enforce. Reset empties the lists,
// sets lag_min to 0 and lag_max to 1; the list memories are not cleared.
module time_tag_window_correlator #(
  parameter int LIST_DEPTH    = 4096,
  parameter int STAMP_BITS    = 48,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire ttc_pkg::item_t               item_i,
  output logic                              result_valid_o,
  output ttc_pkg::result_t                  result_o,
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_index_i,
  input  wire logic [ttc_pkg::LagW-1:0]     cfg_data_i
);

  localparam int SB     = (STAMP_BITS < ttc_pkg::StampW) ? STAMP_BITS : ttc_pkg::StampW;
  localparam int AW     = $clog2(LIST_DEPTH);
  localparam int CW     = $clog2(LIST_DEPTH + 1);
  localparam int LagW   = ttc_pkg::LagW;
  localparam int LW     = ((SB > LagW) ? SB : LagW) + 1;
  localparam int NSW    = ((SB + 1 > LagW + 1) ? SB + 1 : LagW + 1) + 1;
  localparam int DenW   = ttc_pkg::DenW;
  localparam int CountW = ttc_pkg::CountW;
  localparam int PairW  = ttc_pkg::PairW;
  localparam int RatioW = ttc_pkg::RatioW;

  ttc_pkg::state_e state_q, state_d;
  logic [CW-1:0]     fill_a_q, fill_a_d, fill_b_q, fill_b_d;
  logic              ovf_q, ovf_d;
  logic [CW-1:0]     low_q, low_d, high_q, high_d, k_q, k_d, lead_q, lead_d;
  logic [CW-1:0]     early_q, early_d;
  logic [PairW-1:0]  pairs_q, pairs_d;
  logic [SB-1:0]     a_q, a_d;
  logic [NSW-1:0]    num_q, num_d;
  logic [1:0]        status_q, status_d;
  logic [RatioW-1:0] ratio_q, ratio_d;
  logic [LagW-1:0]   lag_min_q, lag_max_q;

  logic              accept, we_a, we_b;
  logic [AW-1:0]     raddr_a, raddr_b;
  logic [SB-1:0]     rdata_a, rdata_b, stamp_in, t_last;
  logic [LW-1:0]     lag_sum, lo_edge, hi_edge;
  logic              zero_win, div_start, div_done;
  logic [DenW-1:0]   den;
  logic [RatioW-1:0] div_quo;
  logic              early_hit;

  assign accept   = start && !busy;
  assign stamp_in = item_i.stamp[SB-1:0];
  assign lag_sum  = LW'(lag_min_q) + LW'(lag_max_q);
  assign lo_edge  = LW'(a_q) + LW'(lag_min_q);
  assign hi_edge  = LW'(a_q) + LW'(lag_max_q);
  assign t_last   = (rdata_b > rdata_a) ? rdata_b : rdata_a;
  assign zero_win = lag_max_q == lag_min_q;
  assign den      = {DenW'({2'b00, lag_max_q} - {2'b00, lag_min_q})} << 1;
  assign early_hit = $signed({1'b0, NSW'({a_q, 1'b0})}) <= $signed({num_q[NSW-1], num_q});

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lag_min_q <= '0;
      lag_max_q <= LagW'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ttc_pkg::CFG_LAG_MIN: lag_min_q <= cfg_data_i;
        ttc_pkg::CFG_LAG_MAX: lag_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ttc_pkg::S_IDLE: begin
        if (accept && item_i.func == ttc_pkg::FUNC_COMPUTE) begin
          state_d = (fill_a_q == '0 || fill_b_q == '0) ? ttc_pkg::S_DONE : ttc_pkg::S_LAST;
        end
      end
      ttc_pkg::S_LAST:     state_d = ttc_pkg::S_TLAST;
      ttc_pkg::S_TLAST:    state_d = ttc_pkg::S_LEAD;
      ttc_pkg::S_LEAD:     state_d = (lead_q < fill_b_q) ? ttc_pkg::S_LEAD_CHK : ttc_pkg::S_RDA;
      ttc_pkg::S_LEAD_CHK: begin
        state_d = (LW'({rdata_b, 1'b0}) < lag_sum) ? ttc_pkg::S_LEAD : ttc_pkg::S_RDA;
      end
      ttc_pkg::S_RDA:      state_d = ttc_pkg::S_GETA;
      ttc_pkg::S_GETA:     state_d = ttc_pkg::S_LOW;
      ttc_pkg::S_LOW:      state_d = (low_q < fill_b_q) ? ttc_pkg::S_LOW_CHK : ttc_pkg::S_HIGH;
      ttc_pkg::S_LOW_CHK:  state_d = (LW'(rdata_b) < lo_edge) ? ttc_pkg::S_LOW : ttc_pkg::S_HIGH;
      ttc_pkg::S_HIGH:     state_d = (high_q < fill_b_q) ? ttc_pkg::S_HIGH_CHK : ttc_pkg::S_ACC;
      ttc_pkg::S_HIGH_CHK: state_d = (LW'(rdata_b) <= hi_edge) ? ttc_pkg::S_HIGH : ttc_pkg::S_ACC;
      ttc_pkg::S_ACC: begin
        if (k_q + 1'b1 < fill_a_q) begin
          state_d = ttc_pkg::S_RDA;
        end else begin
          state_d = zero_win ? ttc_pkg::S_DONE : ttc_pkg::S_DIV;
        end
      end
      ttc_pkg::S_DIV:      state_d = ttc_pkg::S_DIV_WAIT;
      ttc_pkg::S_DIV_WAIT: state_d = div_done ? ttc_pkg::S_DONE : ttc_pkg::S_DIV_WAIT;
      ttc_pkg::S_DONE:     state_d = ttc_pkg::S_IDLE;
      default:             state_d = ttc_pkg::S_IDLE;
    endcase
  end

  // Outputs towards memories, divider and result port.
  always_comb begin
    busy           = state_q != ttc_pkg::S_IDLE;
    result_valid_o = state_q == ttc_pkg::S_DONE;
    div_start      = state_q == ttc_pkg::S_DIV;
    we_a           = accept && item_i.func == ttc_pkg::FUNC_APPEND_A && fill_a_q < CW'(LIST_DEPTH);
    we_b           = accept && item_i.func == ttc_pkg::FUNC_APPEND_B && fill_b_q < CW'(LIST_DEPTH);
    raddr_a        = k_q[AW-1:0];
    raddr_b        = lead_q[AW-1:0];
    case (state_q)
      ttc_pkg::S_LAST: begin
        raddr_a = fill_a_q[AW-1:0] - 1'b1;
        raddr_b = fill_b_q[AW-1:0] - 1'b1;
      end
      ttc_pkg::S_LOW:  raddr_b = low_q[AW-1:0];
      ttc_pkg::S_HIGH: raddr_b = high_q[AW-1:0];
      default: ;
    endcase
  end

  // Datapath registers.
  always_comb begin
    fill_a_d = fill_a_q;
    fill_b_d = fill_b_q;
    ovf_d    = ovf_q;
    low_d    = low_q;
    high_d   = high_q;
    k_d      = k_q;
    lead_d   = lead_q;
    early_d  = early_q;
    pairs_d  = pairs_q;
    a_d      = a_q;
    num_d    = num_q;
    status_d = status_q;
    ratio_d  = ratio_q;
    case (state_q)
      ttc_pkg::S_IDLE: begin
        if (accept) begin
          case (item_i.func)
            ttc_pkg::FUNC_APPEND_A: begin
              if (we_a) fill_a_d = fill_a_q + 1'b1;
              else      ovf_d    = 1'b1;
            end
            ttc_pkg::FUNC_APPEND_B: begin
              if (we_b) fill_b_d = fill_b_q + 1'b1;
              else      ovf_d    = 1'b1;
            end
            ttc_pkg::FUNC_COMPUTE: begin
              early_d  = '0;
              pairs_d  = '0;
              ratio_d  = '0;
              low_d    = '0;
              high_d   = '0;
              k_d      = '0;
              // An empty list reports all counts as zero.
              lead_d   = (fill_a_q == '0 || fill_b_q == '0) ? fill_b_q : '0;
              status_d = ttc_pkg::STATUS_EMPTY;
            end
            default: ;
          endcase
        end
      end
      ttc_pkg::S_TLAST:    num_d = NSW'({t_last, 1'b0}) - NSW'(lag_sum);
      ttc_pkg::S_LEAD_CHK: if (LW'({rdata_b, 1'b0}) < lag_sum) lead_d = lead_q + 1'b1;
      ttc_pkg::S_GETA:     a_d = rdata_a;
      ttc_pkg::S_LOW_CHK:  if (LW'(rdata_b) < lo_edge) low_d = low_q + 1'b1;
      ttc_pkg::S_HIGH_CHK: if (LW'(rdata_b) <= hi_edge) high_d = high_q + 1'b1;
      ttc_pkg::S_ACC: begin
        if (high_q > low_q) pairs_d = pairs_q + PairW'(high_q - low_q);
        if (early_hit)      early_d = early_q + 1'b1;
        k_d = k_q + 1'b1;
        if (zero_win)   status_d = ttc_pkg::STATUS_ZERO_WIN;
        else if (ovf_q) status_d = ttc_pkg::STATUS_OVERFLOW;
        else            status_d = ttc_pkg::STATUS_OK;
      end
      ttc_pkg::S_DIV_WAIT: if (div_done) ratio_d = div_quo;
      ttc_pkg::S_DONE: begin
        fill_a_d = '0;
        fill_b_d = '0;
        ovf_d    = 1'b0;
        low_d    = '0;
        high_d   = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ttc_pkg::S_IDLE;
      fill_a_q <= '0;
      fill_b_q <= '0;
      ovf_q    <= 1'b0;
      low_q    <= '0;
      high_q   <= '0;
      k_q      <= '0;
      lead_q   <= '0;
    end else begin
      state_q  <= state_d;
      fill_a_q <= fill_a_d;
      fill_b_q <= fill_b_d;
      ovf_q    <= ovf_d;
      low_q    <= low_d;
      high_q   <= high_d;
      k_q      <= k_d;
      lead_q   <= lead_d;
    end
  end

  always_ff @(posedge clk_i) begin
    early_q  <= early_d;
    pairs_q  <= pairs_d;
    a_q      <= a_d;
    num_q    <= num_d;
    status_q <= status_d;
    ratio_q  <= ratio_d;
  end

  ttc_ram #(.WIDTH(SB), .DEPTH(LIST_DEPTH)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (fill_a_q[AW-1:0]),
    .wdata_i (stamp_in),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  ttc_ram #(.WIDTH(SB), .DEPTH(LIST_DEPTH)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (fill_b_q[AW-1:0]),
    .wdata_i (stamp_in),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  ttc_divider #(.NUM_W(NSW), .FRAC_W(FRACTION_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign result_o.count_a_early = CountW'(early_q);
  assign result_o.count_b_late  = CountW'(fill_b_q - lead_q);
  assign result_o.pair_count    = pairs_q;
  assign result_o.span_ratio    = ratio_q;
  assign result_o.status        = status_q;

  `TTC_ASSERT(a_compute_busy,
    (accept && item_i.func == ttc_pkg::FUNC_COMPUTE) |=> busy, "compute did not raise busy")
  `TTC_ASSERT(a_strobe_single, result_valid_o |=> !result_valid_o, "result shown twice")
  `TTC_ASSERT(a_done_clears, result_valid_o |=> (fill_a_q == '0 && fill_b_q == '0 && !ovf_q),
    "lists not emptied after a result")
  `TTC_ASSERT_NEVER(a_ptr_range, busy && (low_q > fill_b_q || high_q > fill_b_q),
    "B pointer beyond fill")

endmodule
`default_nettype wire

/* verif/time_tag_window_correlator_test.sv */
`default_nettype none
module time_tag_window_correlator_test;

  localparam int StampW = ttc_pkg::StampW;
  localparam int LagW   = ttc_pkg::LagW;
  localparam int RatioW = ttc_pkg::RatioW;
  localparam int CountW = ttc_pkg::CountW;
  localparam int PairW  = ttc_pkg::PairW;
  localparam int FracBits = 16;
  localparam int unsigned Depth = 4096;
  localparam logic [1:0] FuncUnused = 2'd3;
  localparam logic [StampW-1:0] StampMax = {StampW{1'b1}};
  localparam logic [LagW-1:0] LagMax = {LagW{1'b1}};
  localparam int unsigned StallLimit = 200000;
  localparam int unsigned ItemTarget = 1300;

  typedef struct {
    logic [1:0]        func;
    logic [StampW-1:0] stamp;
    bit                typed;
    ttc_pkg::result_t  want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  ttc_pkg::item_t item_i = '0;
  logic result_valid_o;
  ttc_pkg::result_t result_o;
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = 1'b0;
  logic [LagW-1:0] cfg_data_i = '0;

  // Predictor state.
  logic [StampW-1:0] stamps_a[$];
  logic [StampW-1:0] stamps_b[$];
  bit                dropped;
  logic [LagW-1:0]   lag_lo = '0;
  logic [LagW-1:0]   lag_hi = 32'd1;

  ttc_pkg::result_t pending_results[$];
  stim_row_t   stim_rows[$];
  int unsigned fail_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned status_seen[4] = '{0, 0, 0, 0};
  int unsigned quiet_cycles = 0;
  bit          accepted_now;
  bit          sender_idles = 1'b1;

  time_tag_window_correlator u_top (
    .clk_i, .rst_ni, .start, .busy, .item_i, .result_valid_o, .result_o,
    .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Signed num/den with FracBits fraction bits, truncated, saturated.
  function automatic logic [RatioW-1:0] fixed_quotient(longint num, longint den);
    bit neg;
    longint unsigned n, d, q, r, lim;
    neg = (num < 0) != (den < 0);
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    q = n / d;
    r = n % d;
    if (q > lim) return lim;
    for (int i = 0; i < FracBits; i++) begin
      if (q > (lim >> 1)) return lim;
      q = q << 1;
      r = r << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'd1;
      end
    end
    return neg ? -q : q;
  endfunction

  function automatic ttc_pkg::result_t correlate_lists();
    ttc_pkg::result_t res;
    longint unsigned pairs, lag_sum, t_last;
    longint twice_t, width;
    int unsigned lo, hi, early, lead;
    res = '0;
    res.status = ttc_pkg::STATUS_EMPTY;
    if (stamps_a.size() == 0 || stamps_b.size() == 0) return res;
    lag_sum = longint'(lag_lo) + longint'(lag_hi);
    t_last = stamps_a[$];
    if (stamps_b[$] > t_last) t_last = stamps_b[$];
    twice_t = t_last << 1;
    pairs = 0; lo = 0; hi = 0; early = 0; lead = 0;
    foreach (stamps_a[k]) begin
      while (lo < stamps_b.size() &&
             longint'(stamps_b[lo]) < longint'(stamps_a[k]) + longint'(lag_lo))
        lo++;
      while (hi < stamps_b.size() &&
             longint'(stamps_b[hi]) <= longint'(stamps_a[k]) + longint'(lag_hi))
        hi++;
      if (hi > lo) pairs += hi - lo;
      if (longint'(stamps_a[k]) * 2 <= twice_t - longint'(lag_sum)) early++;
    end
    while (lead < stamps_b.size() && longint'(stamps_b[lead]) * 2 < lag_sum) lead++;
    res.count_a_early = CountW'(early);
    res.count_b_late = CountW'(stamps_b.size() - lead);
    res.pair_count = PairW'(pairs);
    width = longint'(lag_hi) - longint'(lag_lo);
    if (width == 0) begin
      res.span_ratio = '0;
      res.status = ttc_pkg::STATUS_ZERO_WIN;
    end else begin
      res.span_ratio = fixed_quotient(twice_t - longint'(lag_sum), width * 2);
      res.status = dropped ? ttc_pkg::STATUS_OVERFLOW : ttc_pkg::STATUS_OK;
    end
    return res;
  endfunction

  // Updates the predictor for one accepted item; returns 1 when a result follows.
  function automatic bit predict_item(ttc_pkg::item_t it, output ttc_pkg::result_t res);
    res = '0;
    case (it.func)
      ttc_pkg::FUNC_APPEND_B: if (stamps_b.size() < Depth) stamps_b.push_back(it.stamp);
                              else dropped = 1'b1;
      ttc_pkg::FUNC_APPEND_A: if (stamps_a.size() < Depth) stamps_a.push_back(it.stamp);
                              else dropped = 1'b1;
      ttc_pkg::FUNC_COMPUTE: begin
        res = correlate_lists();
        stamps_a.delete();
        stamps_b.delete();
        dropped = 1'b0;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  task automatic send_item(logic [1:0] func, logic [StampW-1:0] stamp, bit typed,
                           ttc_pkg::result_t want);
    int unsigned gap;
    ttc_pkg::item_t it;
    ttc_pkg::result_t res;
    gap = sender_idles ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    it.func = func;
    it.stamp = stamp;
    start <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
    if (predict_item(it, res)) pending_results.push_back(typed ? want : res);
  endtask

  // Waits for the block to drain, then writes one register.
  task automatic write_lag(ttc_pkg::cfg_idx_e idx, logic [LagW-1:0] value);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == ttc_pkg::CFG_LAG_MIN) lag_lo = value;
    else lag_hi = value;
  endtask

  task automatic add_row(logic [1:0] func, logic [StampW-1:0] stamp, bit typed = 0,
                         ttc_pkg::result_t want = '0);
    stim_rows.push_back('{func, stamp, typed, want});
  endtask

  task automatic send_list(logic [1:0] func, int unsigned len, logic [StampW-1:0] base,
                           int unsigned max_step);
    logic [StampW-1:0] s;
    s = base;
    for (int unsigned i = 0; i < len; i++) begin
      send_item(func, s, 0, '0);
      if (StampMax - s > max_step) s = s + StampW'($urandom_range(0, max_step));
      else s = StampMax;
    end
  endtask

  // Result checking and the watchdog.
  always @(posedge clk_i) begin
    accepted_now = rst_ni && start && !busy;
    if (rst_ni && result_valid_o) begin
      accepted_now = 1'b1;
      results_seen++;
      status_seen[result_o.status]++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected");
        fail_count++;
      end else begin
        ttc_pkg::result_t w;
        w = pending_results.pop_front();
        if (result_o.count_a_early !== w.count_a_early) begin
          $error("count_a_early: expected %0d, got %0d", w.count_a_early,
                 result_o.count_a_early);
          fail_count++;
        end
        if (result_o.count_b_late !== w.count_b_late) begin
          $error("count_b_late: expected %0d, got %0d", w.count_b_late,
                 result_o.count_b_late);
          fail_count++;
        end
        if (result_o.pair_count !== w.pair_count) begin
          $error("pair_count: expected %0d, got %0d", w.pair_count, result_o.pair_count);
          fail_count++;
        end
        if (result_o.span_ratio !== w.span_ratio) begin
          $error("span_ratio: expected %h, got %h", w.span_ratio, result_o.span_ratio);
          fail_count++;
        end
        if (result_o.status !== w.status) begin
          $error("status: expected %0d, got %0d", w.status, result_o.status);
          fail_count++;
        end
      end
    end
    quiet_cycles = accepted_now ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("time_tag_window_correlator_test: done, errors");
      $finish;
    end
  end

  initial begin
    ttc_pkg::result_t empty_res;
    logic [LagW-1:0] lo_pick, hi_pick;
    int unsigned phase;
    empty_res = '0;
    empty_res.status = ttc_pkg::STATUS_EMPTY;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty lists, the unused selector, stamp extremes.
    add_row(ttc_pkg::FUNC_COMPUTE, '0, 1, empty_res);
    add_row(ttc_pkg::FUNC_APPEND_A, '0);
    add_row(ttc_pkg::FUNC_COMPUTE, '0, 1, empty_res);
    add_row(ttc_pkg::FUNC_APPEND_B, 48'd7);
    add_row(ttc_pkg::FUNC_COMPUTE, '0, 1, empty_res);
    add_row(FuncUnused, StampMax);
    add_row(ttc_pkg::FUNC_APPEND_A, '0);
    add_row(ttc_pkg::FUNC_APPEND_A, 48'd1);
    add_row(ttc_pkg::FUNC_APPEND_B, '0);
    add_row(ttc_pkg::FUNC_APPEND_B, 48'd1);
    add_row(ttc_pkg::FUNC_APPEND_B, 48'd2);
    add_row(ttc_pkg::FUNC_COMPUTE, '0);
    add_row(ttc_pkg::FUNC_APPEND_A, StampMax - 1);
    add_row(ttc_pkg::FUNC_APPEND_B, StampMax - 1);
    add_row(ttc_pkg::FUNC_APPEND_B, StampMax);
    add_row(ttc_pkg::FUNC_APPEND_A, StampMax);
    add_row(ttc_pkg::FUNC_COMPUTE, '0);
    add_row(FuncUnused, '0);
    add_row(ttc_pkg::FUNC_COMPUTE, '0, 1, empty_res);
    foreach (stim_rows[i])
      send_item(stim_rows[i].func, stim_rows[i].stamp, stim_rows[i].typed,
                stim_rows[i].want);

    // Zero window and reversed full-range window, each on fresh short lists.
    for (int unsigned k = 0; k < 2; k++) begin
      write_lag(ttc_pkg::CFG_LAG_MIN, k == 0 ? 32'd1 : LagMax);
      write_lag(ttc_pkg::CFG_LAG_MAX, k == 0 ? 32'd1 : 32'd0);
      send_list(ttc_pkg::FUNC_APPEND_A, 4, 48'd0, 3);
      send_list(ttc_pkg::FUNC_APPEND_B, 4, 48'd1, 3);
      send_item(ttc_pkg::FUNC_COMPUTE, '0, 0, '0);
    end

    // Long lists sent back to back, then a pause until every result has come.
    write_lag(ttc_pkg::CFG_LAG_MIN, 32'd0);
    write_lag(ttc_pkg::CFG_LAG_MAX, 32'd40);
    sender_idles = 1'b0;
    send_list(ttc_pkg::FUNC_APPEND_A, 200, 48'd100, 4);
    send_list(ttc_pkg::FUNC_APPEND_B, 200, 48'd50, 6);
    send_item(ttc_pkg::FUNC_COMPUTE, '0, 0, '0);
    sender_idles = 1'b1;
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);

    phase = 0;
    while (items_sent < ItemTarget) begin
      case (phase % 6)
        0: begin lo_pick = 0; hi_pick = LagMax; end
        1: begin lo_pick = LagMax; hi_pick = LagMax; end
        2: begin lo_pick = $urandom; hi_pick = $urandom; end
        3: begin lo_pick = $urandom_range(30, 60); hi_pick = $urandom_range(0, 30); end
        default: begin
          lo_pick = $urandom_range(0, 40);
          hi_pick = lo_pick + $urandom_range(0, 40);
        end
      endcase
      write_lag(ttc_pkg::CFG_LAG_MIN, lo_pick);
      write_lag(ttc_pkg::CFG_LAG_MAX, hi_pick);
      sender_idles = (phase % 4) != 3;
      repeat (6) begin
        logic [StampW-1:0] base;
        base = StampW'({$urandom, $urandom});
        if ($urandom_range(0, 3) == 0) base = StampW'($urandom_range(0, 100));
        if (base > StampMax - 2000) base = StampMax - StampW'($urandom_range(0, 2000));
        if ($urandom_range(0, 9) == 0) begin
          // Noise: unordered stamps, the unused selector, lists left empty.
          repeat ($urandom_range(0, 6))
            send_item(2'($urandom_range(0, 3)), StampW'({$urandom, $urandom}), 0, '0);
        end else begin
          send_list(ttc_pkg::FUNC_APPEND_A, $urandom_range(0, 24), base,
                    $urandom_range(1, 40));
          send_list(ttc_pkg::FUNC_APPEND_B, $urandom_range(0, 24),
                    base + StampW'($urandom_range(0, 30)), $urandom_range(1, 40));
        end
        send_item(ttc_pkg::FUNC_COMPUTE, StampW'({$urandom, $urandom}), 0, '0);
      end
      phase++;
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Run covered %0d transfers in, %0d results out.", items_sent, results_seen);
    $display("Statuses ok/empty/zero window/overflow: %0d/%0d/%0d/%0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (fail_count == 0) begin
      $display("time_tag_window_correlator_test: done, clean");
    end else begin
      $display("time_tag_window_correlator_test: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
